@@ src/tcps_pkg.sv @@
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types, constants and helpers for the tile collision physics step.
// ----------------------------------------------------------------------------
package tcps_pkg;

   localparam int MAP_WIDTH_DEF  = 64;
   localparam int MAP_HEIGHT_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   localparam logic [31:0] POS_X_RESET = 32'd655360;
   localparam logic [31:0] POS_Y_RESET = 32'd327680;

   localparam logic [16:0] DAMP_RESET  = 17'd65536;
   localparam logic [30:0] TERM_RESET  = 31'd1310720;
   localparam logic [22:0] BOX_RESET   = 23'd65536;

   // register indexes
   localparam logic [2:0] REG_DAMP  = 3'd0;
   localparam logic [2:0] REG_TERM  = 3'd1;
   localparam logic [2:0] REG_ACCX  = 3'd2;
   localparam logic [2:0] REG_ACCY  = 3'd3;
   localparam logic [2:0] REG_BOXW  = 3'd4;
   localparam logic [2:0] REG_BOXH  = 3'd5;

   localparam logic FUNC_FILL = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_KIN,
      ST_CLAMP,
      ST_RES_INIT,
      ST_PROBE,
      ST_APPLY,
      ST_STORE,
      ST_OUT
   } state_type;

   // kinematics micro-ops, one multiply each
   typedef enum logic [3:0] {
      K_VX_DIR,
      K_HX1,
      K_HY1,
      K_MX,
      K_MY,
      K_HX2,
      K_HY2,
      K_DAMP,
      K_NONE
   } kop_type;

   // controller to datapath
   typedef struct packed {
      logic       clr_step;
      logic       fill_start;
      logic       fill_step;
      logic       load_step;
      kop_type    kop;
      logic       clamp;
      logic       res_init;    // start of a resolve pass
      logic       probe;       // look up one corner
      logic [1:0] probe_sel;
      logic [1:0] phase;       // 0 y edge, 1 x edge, 2 corners
      logic       apply;
      logic       second_pass;
      logic       store;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic fill_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)       return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

endpackage

@@ src/tcps_if.sv @@
// ----------------------------------------------------------------------------
// tcps_req_if / tcps_rsp_if
// Valid/ready channels carrying a request beat and a result beat.
// ----------------------------------------------------------------------------
interface tcps_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [5:0]         tile_x;
   logic [5:0]         tile_y;
   logic [6:0]         fill_width;
   logic [6:0]         fill_height;
   logic               physics_on;
   logic signed [31:0] speed;
   logic signed [1:0]  direction;
   logic [30:0]        time_step;
   modport source (output valid, func, tile_x, tile_y, fill_width, fill_height,
                   physics_on, speed, direction, time_step, input ready);
   modport sink   (input valid, func, tile_x, tile_y, fill_width, fill_height,
                   physics_on, speed, direction, time_step, output ready);
endinterface

interface tcps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

@@ src/tile_collision_physics_step.sv @@
// Fill item: a sweep over the fill_width x fill_height rectangle, then the result.
// Step item: 4 (physics off) or 7 (physics on) multiply ops, clamp, two resolve
// passes of an init step and 3 x (4 tile reads + apply) each, then store.
// One item at a time; the next is taken in the cycle after the result beat leaves.
// After reset a clearing pass empties the map before the first item is accepted;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// tile_collision_physics_step
// Top level: APB register file, controller and datapath.
// ----------------------------------------------------------------------------
module tile_collision_physics_step
   import tcps_pkg::*;
#(
   parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   tcps_req_if.sink    req,
   tcps_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [16:0]        damp_ff;
   logic [30:0]        term_ff;
   logic signed [31:0] accx_ff, accy_ff;
   logic [22:0]        boxw_ff, boxh_ff;
   logic [2:0]         ridx;
   logic               wr;

   assign csr_pready = 1'b1;
   assign ridx       = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff <= DAMP_RESET;
         term_ff <= TERM_RESET;
         accx_ff <= '0;
         accy_ff <= '0;
         boxw_ff <= BOX_RESET;
         boxh_ff <= BOX_RESET;
      end else if (wr) begin
         case (ridx)
            REG_DAMP: damp_ff <= csr_pwdata[16:0];
            REG_TERM: term_ff <= csr_pwdata[30:0];
            REG_ACCX: accx_ff <= csr_pwdata;
            REG_ACCY: accy_ff <= csr_pwdata;
            REG_BOXW: boxw_ff <= csr_pwdata[22:0];
            REG_BOXH: boxh_ff <= csr_pwdata[22:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (ridx)
         REG_DAMP: csr_prdata = 32'(damp_ff);
         REG_TERM: csr_prdata = 32'(term_ff);
         REG_ACCX: csr_prdata = accx_ff;
         REG_ACCY: csr_prdata = accy_ff;
         REG_BOXW: csr_prdata = 32'(boxw_ff);
         REG_BOXH: csr_prdata = 32'(boxh_ff);
         default:  csr_prdata = '0;
      endcase
   end

   cmd_type cmd;
   sts_type sts;

   tcps_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_func       (req.func),
      .req_physics_on (req.physics_on),
      .req_ready      (req.ready),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .sts            (sts),
      .cmd            (cmd)
   );

   tcps_dp #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_tile_x      (req.tile_x),
      .req_tile_y      (req.tile_y),
      .req_fill_width  (req.fill_width),
      .req_fill_height (req.fill_height),
      .req_speed       (req.speed),
      .req_direction   (req.direction),
      .req_time_step   (req.time_step),
      .damping_factor  (damp_ff),
      .terminal_speed  (term_ff),
      .accel_x         (accx_ff),
      .accel_y         (accy_ff),
      .box_width       (boxw_ff),
      .box_height      (boxh_ff),
      .pos_x           (rsp.pos_x),
      .pos_y           (rsp.pos_y),
      .vel_x           (rsp.vel_x),
      .vel_y           (rsp.vel_y)
   );

endmodule

@@ src/tcps_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcps_ctrl
// Sequencer: clear pass, fill sweep, kinematics ops, two resolve passes.
// ----------------------------------------------------------------------------
module tcps_ctrl
   import tcps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   input  logic    req_physics_on,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   kop_type   kop_ff, kop_in;
   logic      phys_ff, phys_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] sel_ff, sel_in;
   logic       pass_ff, pass_in;

   // next-op sequence for kinematics
   function automatic kop_type next_kop(input kop_type k, input logic ph);
      case (k)
         K_VX_DIR: return K_HY1;
         K_HX1:    return K_HY1;
         K_HY1:    return K_MX;
         K_MX:     return K_MY;
         K_MY:     return ph ? K_HX2 : K_NONE;
         K_HX2:    return K_HY2;
         K_HY2:    return K_DAMP;
         K_DAMP:   return K_NONE;
         default:  return K_NONE;
      endcase
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      kop_in   = kop_ff;
      phys_in  = phys_ff;
      phase_in = phase_ff;
      sel_in   = sel_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_FILL) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_KIN;
                  phys_in  = req_physics_on;
                  kop_in   = req_physics_on ? K_HX1 : K_VX_DIR;
               end
            end
         end
         ST_FILL: if (sts.fill_done) state_in = ST_OUT;
         ST_KIN: begin
            kop_in = next_kop(kop_ff, phys_ff);
            if (next_kop(kop_ff, phys_ff) == K_NONE) state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = ST_RES_INIT;
            pass_in  = 1'b0;
         end
         ST_RES_INIT: begin
            state_in = ST_PROBE;
            phase_in = 2'd0;
            sel_in   = 2'd0;
         end
         ST_PROBE: begin
            sel_in = sel_ff + 2'd1;
            if (sel_ff == 2'd3) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            sel_in = 2'd0;
            if (phase_ff == 2'd2) begin
               if (pass_ff) begin
                  state_in = ST_STORE;
               end else begin
                  pass_in  = 1'b1;
                  state_in = ST_RES_INIT;
               end
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = ST_PROBE;
            end
         end
         ST_STORE: state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd             = '0;
      cmd.kop         = K_NONE;
      cmd.probe_sel   = sel_ff;
      cmd.phase       = phase_ff;
      cmd.second_pass = pass_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.fill_start = req_valid && (req_func == FUNC_FILL);
            cmd.load_step  = req_valid && (req_func == FUNC_STEP);
         end
         ST_FILL:     cmd.fill_step = 1'b1;
         ST_KIN:      cmd.kop = kop_ff;
         ST_CLAMP:    cmd.clamp = 1'b1;
         ST_RES_INIT: cmd.res_init = 1'b1;
         ST_PROBE:    cmd.probe = 1'b1;
         ST_APPLY:    cmd.apply = 1'b1;
         ST_STORE:    cmd.store = 1'b1;
         ST_OUT:      rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kop_ff   <= K_NONE;
         phys_ff  <= 1'b0;
         phase_ff <= 2'd0;
         sel_ff   <= 2'd0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kop_ff   <= kop_in;
         phys_ff  <= phys_in;
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

@@ src/tcps_dp.sv @@
// ----------------------------------------------------------------------------
// tcps_dp
// Datapath: box state, shared multiplier, tile map memory, resolve logic.
// ----------------------------------------------------------------------------
module tcps_dp
   import tcps_pkg::*;
#(
   parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [5:0]         req_tile_x,
   input  logic [5:0]         req_tile_y,
   input  logic [6:0]         req_fill_width,
   input  logic [6:0]         req_fill_height,
   input  logic signed [31:0] req_speed,
   input  logic signed [1:0]  req_direction,
   input  logic [30:0]        req_time_step,
   input  logic [16:0]        damping_factor,
   input  logic [30:0]        terminal_speed,
   input  logic signed [31:0] accel_x,
   input  logic signed [31:0] accel_y,
   input  logic [22:0]        box_width,
   input  logic [22:0]        box_height,
   output logic signed [31:0] pos_x,
   output logic signed [31:0] pos_y,
   output logic signed [31:0] vel_x,
   output logic signed [31:0] vel_y
);

   localparam int XW    = $clog2(MAP_WIDTH);
   localparam int YW    = $clog2(MAP_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int WP    = 40;   // wide position during resolve
   localparam logic signed [WP-1:0] ONE = WP'(1) <<< FRAC_BITS;

   // ---------------- box state ----------------
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff;
   logic signed [31:0] kpx_ff, kpy_ff, kvx_ff, kvy_ff;   // working copies
   logic signed [31:0] spd_ff;
   logic signed [2:0]  dir_ff;
   logic [30:0]        dt_ff;

   // ---------------- shared multiplier ----------------
   logic signed [32:0] ma;
   logic signed [32:0] mb;
   logic signed [65:0] prod;
   logic [5:0]         shamt;
   always_comb begin
      ma    = 33'(kvx_ff);
      mb    = $signed({2'b00, dt_ff});
      shamt = 6'(FRAC_BITS);
      case (cmd.kop)
         K_VX_DIR: begin ma = 33'(spd_ff); mb = 33'(dir_ff); shamt = 6'd0; end
         K_HX1, K_HX2: begin ma = 33'(accel_x); shamt = 6'(FRAC_BITS + 1); end
         K_HY1, K_HY2: begin ma = 33'(accel_y); shamt = 6'(FRAC_BITS + 1); end
         K_MX:   ma = 33'(kvx_ff);
         K_MY:   ma = 33'(kvy_ff);
         K_DAMP: begin ma = 33'(kvx_ff); mb = $signed({16'd0, damping_factor}); end
         default: ;
      endcase
      prod = (66'(ma) * 66'(mb)) >>> shamt;
   end

   // clamp helper
   function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                 input logic [30:0] t);
      logic signed [32:0] tp;
      tp = $signed({2'b00, t});
      if (33'(v) > tp)       return tp[31:0];
      else if (33'(v) < -tp) return 32'(-tp);
      else                   return v;
   endfunction

   // ---------------- tile map memory ----------------
   logic             map_mem [DEPTH];
   logic [AW:0]      clr_cnt_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic             mem_rd_ff;
   logic [AW-1:0]    mem_raddr;
   logic             rd_inb_ff;

   // fill sweep counters
   logic [6:0] fi_ff, fj_ff;
   logic [5:0] fx0_ff, fy0_ff;
   logic [6:0] fw_ff, fh_ff;
   logic [7:0] ftx, fty;
   logic       f_inb;
   assign ftx   = 8'(fx0_ff) + 8'(fj_ff);
   assign fty   = 8'(fy0_ff) + 8'(fi_ff);
   assign f_inb = (32'(ftx) < 32'(MAP_WIDTH)) && (32'(fty) < 32'(MAP_HEIGHT)) &&
                  (fj_ff < fw_ff) && (fi_ff < fh_ff);
   assign sts.fill_done = cmd.fill_step &&
                          ((fw_ff == 7'd0) || (fh_ff == 7'd0) ||
                           ((fj_ff == fw_ff - 7'd1) && (fi_ff == fh_ff - 7'd1)));
   assign sts.clr_done  = clr_cnt_ff == (AW + 1)'(DEPTH - 1);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff[AW-1:0];
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else if (cmd.fill_step && f_inb) begin
         mem_we    = 1'b1;
         mem_waddr = (AW'(fty) << XW) | AW'(ftx);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= !cmd.clr_step;
      mem_rd_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_start) begin
         fx0_ff <= req_tile_x;
         fy0_ff <= req_tile_y;
         fw_ff  <= req_fill_width;
         fh_ff  <= req_fill_height;
         fi_ff  <= '0;
         fj_ff  <= '0;
      end else if (cmd.fill_step) begin
         if (fj_ff == fw_ff - 7'd1) begin
            fj_ff <= '0;
            fi_ff <= fi_ff + 7'd1;
         end else begin
            fj_ff <= fj_ff + 7'd1;
         end
      end
   end

   // ---------------- resolve ----------------
   logic signed [WP-1:0] rpx_ff, rpy_ff, rvx_ff, rvy_ff;
   logic [3:0]           hit_ff;   // 0 tl, 1 tr, 2 bl, 3 br
   logic [1:0]           psel_ff;
   logic                 pvalid_ff;
   logic signed [WP-1:0] qx, qy;
   logic [WP-YW-FRAC_BITS-1:0] tyw;
   logic [WP-XW-FRAC_BITS-1:0] txw;
   logic                 q_inb;

   // corner select: bit0 adds width, bit1 adds height
   always_comb begin
      qx  = rpx_ff + (cmd.probe_sel[0] ? WP'(box_width)  : '0);
      qy  = rpy_ff + (cmd.probe_sel[1] ? WP'(box_height) : '0);
      txw = qx[WP-1:FRAC_BITS+XW];
      tyw = qy[WP-1:FRAC_BITS+YW];
      q_inb = (txw == '0) && (tyw == '0) &&
              ({1'b0, qx[FRAC_BITS+XW-1:FRAC_BITS]} < (XW+1)'(MAP_WIDTH)) &&
              ({1'b0, qy[FRAC_BITS+YW-1:FRAC_BITS]} < (YW+1)'(MAP_HEIGHT));
      mem_raddr = {qy[FRAC_BITS+YW-1:FRAC_BITS], qx[FRAC_BITS+XW-1:FRAC_BITS]};
   end

   function automatic logic signed [WP-1:0] floorq(input logic signed [WP-1:0] p);
      return (p >>> FRAC_BITS) <<< FRAC_BITS;
   endfunction
   function automatic logic signed [WP-1:0] ceilq(input logic signed [WP-1:0] p);
      return (floorq(p) == p) ? p : floorq(p) + ONE;
   endfunction

   // record hits; the read data is registered and lands in the cycle after its address
   always_ff @(posedge clock) begin
      pvalid_ff <= cmd.probe;
      psel_ff   <= cmd.probe_sel;
      rd_inb_ff <= q_inb;
      if (cmd.res_init || cmd.apply) hit_ff <= '0;
      else if (pvalid_ff) hit_ff[psel_ff] <= mem_rd_ff && rd_inb_ff;
   end

   // last probe result lands during the apply cycle; merge it
   logic [3:0] hit_all;
   always_comb begin
      hit_all = hit_ff;
      if (pvalid_ff) hit_all[psel_ff] = mem_rd_ff && rd_inb_ff;
   end

   logic signed [WP-1:0] ndx, ndy;
   always_comb begin
      logic a0, a1, a2, a3;
      a0 = hit_all[0]; a1 = hit_all[1]; a2 = hit_all[2]; a3 = hit_all[3];
      ndx = '0; ndy = '0;
      if (a0) begin
         ndx = ceilq(rpx_ff) - rpx_ff;  ndy = ceilq(rpy_ff) - rpy_ff;
      end else if (a2) begin
         ndx = ceilq(rpx_ff) - rpx_ff;  ndy = rpy_ff - floorq(rpy_ff);
      end else if (a3) begin
         ndx = rpx_ff - floorq(rpx_ff); ndy = rpy_ff - floorq(rpy_ff);
      end else if (a1) begin
         ndx = rpx_ff - floorq(rpx_ff); ndy = ceilq(rpy_ff) - rpy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= POS_X_RESET;
         py_ff <= POS_Y_RESET;
         vx_ff <= '0;
         vy_ff <= '0;
      end else if (cmd.store) begin
         px_ff <= sat32(66'(rpx_ff));
         py_ff <= sat32(66'(rpy_ff));
         vx_ff <= sat32(66'(rvx_ff));
         vy_ff <= sat32(66'(rvy_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_step) begin
         kpx_ff <= px_ff; kpy_ff <= py_ff;
         kvx_ff <= vx_ff; kvy_ff <= vy_ff;
         spd_ff <= req_speed;
         dir_ff <= 3'(req_direction);
         dt_ff  <= req_time_step;
      end
      case (cmd.kop)
         K_VX_DIR:     kvx_ff <= sat32(prod);
         K_HX1, K_HX2: kvx_ff <= sat32(66'(kvx_ff) + prod);
         K_HY1, K_HY2: kvy_ff <= sat32(66'(kvy_ff) + prod);
         K_MX:         kpx_ff <= sat32(66'(kpx_ff) + 66'(sat32(prod)));
         K_MY:         kpy_ff <= sat32(66'(kpy_ff) + 66'(sat32(prod)));
         K_DAMP:       kvx_ff <= sat32(prod);
         default: ;
      endcase
      if (cmd.clamp) begin
         kvx_ff <= clampv(kvx_ff, terminal_speed);
         kvy_ff <= clampv(kvy_ff, terminal_speed);
      end
      if (cmd.res_init) begin
         if (!cmd.second_pass) begin
            rpx_ff <= WP'(kpx_ff);
            rpy_ff <= WP'(py_ff);
            rvx_ff <= WP'(kvx_ff);
            rvy_ff <= '0;
         end else begin
            rpy_ff <= WP'(kpy_ff);
            rvy_ff <= WP'(kvy_ff);
         end
      end
      if (cmd.apply) begin
         case (cmd.phase)
            2'd0: begin
               if (hit_all[0] && hit_all[1]) begin
                  rpy_ff <= ceilq(rpy_ff); rvy_ff <= '0;
               end else if (hit_all[2] && hit_all[3]) begin
                  rpy_ff <= floorq(rpy_ff); rvy_ff <= '0;
               end
            end
            2'd1: begin
               if (hit_all[0] && hit_all[2]) begin
                  rpx_ff <= ceilq(rpx_ff); rvx_ff <= '0;
               end else if (hit_all[1] && hit_all[3]) begin
                  rpx_ff <= floorq(rpx_ff); rvx_ff <= '0;
               end
            end
            default: begin
               if (hit_all[0] || hit_all[2]) begin
                  if (ndx > ndy) begin
                     rpy_ff <= hit_all[0] ? ceilq(rpy_ff) : floorq(rpy_ff);
                     rvy_ff <= '0;
                  end else begin
                     rpx_ff <= ceilq(rpx_ff); rvx_ff <= '0;
                  end
               end else if (hit_all[3] || hit_all[1]) begin
                  if (ndx > ndy) begin
                     rpy_ff <= hit_all[3] ? floorq(rpy_ff) : ceilq(rpy_ff);
                     rvy_ff <= '0;
                  end else begin
                     rpx_ff <= floorq(rpx_ff); rvx_ff <= '0;
                  end
               end
            end
         endcase
      end
   end

   assign pos_x = px_ff;
   assign pos_y = py_ff;
   assign vel_x = vx_ff;
   assign vel_y = vy_ff;

endmodule

@@ src/tcps_checker.sv @@
// ----------------------------------------------------------------------------
// tcps_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module tcps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");

   // no new request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req ready with rsp pending");

   // an accepted request never yields a result in the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");

endmodule

bind tile_collision_physics_step tcps_checker u_tcps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
